[rtl/core/bfism_pkg.sv]
// shared types, codes and helpers of the instruction step machine
package bfism_pkg;

  localparam int unsigned PROG_DEPTH_DEF = 4096;
  localparam int unsigned TAPE_DEPTH_DEF = 4096;
  localparam int unsigned NEXT_IP_W      = 13;
  localparam int unsigned FUNC_W         = 2;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned OP_W           = 4;

  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_STEP    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef enum logic [OP_W-1:0] {
    OP_NOP   = 4'd0,
    OP_RIGHT = 4'd1,
    OP_LEFT  = 4'd2,
    OP_INC   = 4'd3,
    OP_DEC   = 4'd4,
    OP_OUT   = 4'd5,
    OP_IN    = 4'd6,
    OP_OPEN  = 4'd7,
    OP_CLOSE = 4'd8
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_END       = 3'd1,
    STAT_UNDER     = 3'd2,
    STAT_OVER      = 3'd3,
    STAT_UNMATCHED = 3'd4,
    STAT_FULL      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN_F,
    S_SCAN_B
  } ctrl_state_e;

  typedef enum logic [2:0] {
    PRD_K,
    PRD_IP,
    PRD_IP_P1,
    PRD_IP_M1,
    PRD_K_P1,
    PRD_K_M1
  } prd_sel_e;

  typedef enum logic [1:0] {
    IP_HOLD,
    IP_INC,
    IP_SCAN
  } ip_sel_e;

  typedef enum logic [1:0] {
    TS_INC,
    TS_DEC,
    TS_IN
  } tape_src_e;

  typedef struct packed {
    logic      prog_wr;
    logic      clr_regs;
    logic      sweep_wr;
    logic      latch_in;
    prd_sel_e  prd_sel;
    ip_sel_e   ip_sel;
    logic      cp_inc;
    logic      cp_dec;
    logic      fault_set;
    logic      tape_wr;
    tape_src_e tsrc;
    logic      depth_clr;
    logic      depth_inc;
    logic      depth_dec;
    logic      emit;
    logic      out_sel;
    status_e   status;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic cell_zero;
    logic fault;
    logic ip_ge_len;
    logic ip1_ge_len;
    logic ip_zero;
    logic len_full;
    logic cp_zero;
    logic cp_last;
    logic k_last;
    logic k_zero;
    logic depth_zero;
    logic sweep_last;
  } dp_stat_t;

  function automatic op_e encode(input logic [BYTE_W-1:0] ch);
    op_e op;
    unique case (ch)
      CH_RIGHT: op = OP_RIGHT;
      CH_LEFT:  op = OP_LEFT;
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

[rtl/core/bfism_ctrl.sv]
// controller state machine of the instruction step machine
module bfism_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic [bfism_pkg::FUNC_W-1:0]        func_i,
  input  bfism_pkg::dp_stat_t                 stat_i,
  output bfism_pkg::dp_cmd_t                  cmd_o,
  output logic                                busy
);

  bfism_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfism_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != bfism_pkg::S_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.prd_sel = bfism_pkg::PRD_K;
    cmd_o.ip_sel  = bfism_pkg::IP_HOLD;
    cmd_o.tsrc    = bfism_pkg::TS_INC;
    cmd_o.status  = bfism_pkg::STAT_OK;
    state_d       = state_q;
    unique case (state_q)
      bfism_pkg::S_CLEAR: begin
        cmd_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = bfism_pkg::S_IDLE;
        end
      end
      bfism_pkg::S_IDLE: begin
        if (start) begin
          unique case (bfism_pkg::func_e'(func_i))
            bfism_pkg::FUNC_LOAD: begin
              cmd_o.emit = 1'b1;
              if (stat_i.len_full) begin
                cmd_o.status = bfism_pkg::STAT_FULL;
              end else begin
                cmd_o.prog_wr = 1'b1;
              end
            end
            bfism_pkg::FUNC_STEP: begin
              cmd_o.latch_in = 1'b1;
              if (stat_i.ip_ge_len) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = bfism_pkg::STAT_END;
              end else begin
                cmd_o.prd_sel = bfism_pkg::PRD_IP;
                state_d       = bfism_pkg::S_EXEC;
              end
            end
            bfism_pkg::FUNC_RESTART: begin
              cmd_o.clr_regs = 1'b1;
              cmd_o.emit     = 1'b1;
              state_d        = bfism_pkg::S_CLEAR;
            end
            default: begin
              cmd_o.emit = 1'b1;
            end
          endcase
        end
      end
      bfism_pkg::S_EXEC: begin
        state_d = bfism_pkg::S_IDLE;
        if (stat_i.fault) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = (stat_i.op == bfism_pkg::OP_LEFT) ? bfism_pkg::STAT_UNDER
                                                           : bfism_pkg::STAT_OVER;
        end else begin
          unique case (stat_i.op)
            bfism_pkg::OP_RIGHT: begin
              cmd_o.emit = 1'b1;
              if (stat_i.cp_last) begin
                cmd_o.fault_set = 1'b1;
                cmd_o.status    = bfism_pkg::STAT_OVER;
              end else begin
                cmd_o.cp_inc = 1'b1;
                cmd_o.ip_sel = bfism_pkg::IP_INC;
              end
            end
            bfism_pkg::OP_LEFT: begin
              cmd_o.emit = 1'b1;
              if (stat_i.cp_zero) begin
                cmd_o.fault_set = 1'b1;
                cmd_o.status    = bfism_pkg::STAT_UNDER;
              end else begin
                cmd_o.cp_dec = 1'b1;
                cmd_o.ip_sel = bfism_pkg::IP_INC;
              end
            end
            bfism_pkg::OP_INC, bfism_pkg::OP_DEC, bfism_pkg::OP_IN: begin
              cmd_o.emit    = 1'b1;
              cmd_o.tape_wr = 1'b1;
              cmd_o.ip_sel  = bfism_pkg::IP_INC;
              cmd_o.tsrc    = (stat_i.op == bfism_pkg::OP_INC) ? bfism_pkg::TS_INC :
                              (stat_i.op == bfism_pkg::OP_DEC) ? bfism_pkg::TS_DEC :
                                                                 bfism_pkg::TS_IN;
            end
            bfism_pkg::OP_OUT: begin
              cmd_o.emit    = 1'b1;
              cmd_o.out_sel = 1'b1;
              cmd_o.ip_sel  = bfism_pkg::IP_INC;
            end
            bfism_pkg::OP_OPEN: begin
              if (!stat_i.cell_zero) begin
                cmd_o.emit   = 1'b1;
                cmd_o.ip_sel = bfism_pkg::IP_INC;
              end else if (stat_i.ip1_ge_len) begin
                cmd_o.emit   = 1'b1;
                cmd_o.ip_sel = bfism_pkg::IP_INC;
                cmd_o.status = bfism_pkg::STAT_UNMATCHED;
              end else begin
                cmd_o.prd_sel   = bfism_pkg::PRD_IP_P1;
                cmd_o.depth_clr = 1'b1;
                state_d         = bfism_pkg::S_SCAN_F;
              end
            end
            bfism_pkg::OP_CLOSE: begin
              if (stat_i.cell_zero) begin
                cmd_o.emit   = 1'b1;
                cmd_o.ip_sel = bfism_pkg::IP_INC;
              end else if (stat_i.ip_zero) begin
                cmd_o.emit   = 1'b1;
                cmd_o.ip_sel = bfism_pkg::IP_INC;
                cmd_o.status = bfism_pkg::STAT_UNMATCHED;
              end else begin
                cmd_o.prd_sel   = bfism_pkg::PRD_IP_M1;
                cmd_o.depth_clr = 1'b1;
                state_d         = bfism_pkg::S_SCAN_B;
              end
            end
            default: begin
              cmd_o.emit   = 1'b1;
              cmd_o.ip_sel = bfism_pkg::IP_INC;
            end
          endcase
        end
      end
      bfism_pkg::S_SCAN_F: begin
        if (stat_i.op == bfism_pkg::OP_CLOSE && stat_i.depth_zero) begin
          cmd_o.emit   = 1'b1;
          cmd_o.ip_sel = bfism_pkg::IP_SCAN;
          state_d      = bfism_pkg::S_IDLE;
        end else begin
          cmd_o.depth_dec = (stat_i.op == bfism_pkg::OP_CLOSE);
          cmd_o.depth_inc = (stat_i.op == bfism_pkg::OP_OPEN);
          if (stat_i.k_last) begin
            cmd_o.emit   = 1'b1;
            cmd_o.ip_sel = bfism_pkg::IP_INC;
            cmd_o.status = bfism_pkg::STAT_UNMATCHED;
            state_d      = bfism_pkg::S_IDLE;
          end else begin
            cmd_o.prd_sel = bfism_pkg::PRD_K_P1;
          end
        end
      end
      bfism_pkg::S_SCAN_B: begin
        if (stat_i.op == bfism_pkg::OP_OPEN && stat_i.depth_zero) begin
          cmd_o.emit   = 1'b1;
          cmd_o.ip_sel = bfism_pkg::IP_SCAN;
          state_d      = bfism_pkg::S_IDLE;
        end else begin
          cmd_o.depth_dec = (stat_i.op == bfism_pkg::OP_OPEN);
          cmd_o.depth_inc = (stat_i.op == bfism_pkg::OP_CLOSE);
          if (stat_i.k_zero) begin
            cmd_o.emit   = 1'b1;
            cmd_o.ip_sel = bfism_pkg::IP_INC;
            cmd_o.status = bfism_pkg::STAT_UNMATCHED;
            state_d      = bfism_pkg::S_IDLE;
          end else begin
            cmd_o.prd_sel = bfism_pkg::PRD_K_M1;
          end
        end
      end
      default: begin
        state_d = bfism_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/bfism_datapath.sv]
// datapath of the instruction step machine: pointers, program and tape memories
module bfism_datapath #(
  parameter int unsigned PROG_DEPTH = bfism_pkg::PROG_DEPTH_DEF,
  parameter int unsigned TAPE_DEPTH = bfism_pkg::TAPE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bfism_pkg::BYTE_W-1:0]        prog_char_i,
  input  logic [bfism_pkg::BYTE_W-1:0]        in_byte_i,
  input  bfism_pkg::dp_cmd_t                  cmd_i,
  output bfism_pkg::dp_stat_t                 stat_o,
  output logic                                done_o,
  output logic                                out_valid_o,
  output logic [bfism_pkg::BYTE_W-1:0]        out_byte_o,
  output logic [bfism_pkg::STATUS_W-1:0]      status_o,
  output logic [bfism_pkg::NEXT_IP_W-1:0]     next_ip_o
);

  localparam int unsigned IPW = $clog2(PROG_DEPTH + 1);
  localparam int unsigned AW  = $clog2(PROG_DEPTH);
  localparam int unsigned CW  = $clog2(TAPE_DEPTH);

  logic [bfism_pkg::OP_W-1:0]   prog_mem [PROG_DEPTH];
  logic [bfism_pkg::BYTE_W-1:0] tape_mem [TAPE_DEPTH];

  logic [IPW-1:0] len_q, len_d, ip_q, ip_d, depth_q, depth_d;
  logic [CW-1:0]  cp_q, cp_d, sweep_q, sweep_d;
  logic           fault_q, fault_d;
  logic [AW-1:0]  scan_k_q, rd_addr;
  logic [bfism_pkg::BYTE_W-1:0] in_byte_q, tape_rd_q, tape_wdata;
  logic [bfism_pkg::OP_W-1:0]   prog_rd_q;
  logic [CW-1:0]  tape_waddr;
  logic           tape_we;
  logic [IPW:0]   ip_p1, k_p1;

  logic                              done_q;
  logic                              out_valid_q;
  logic [bfism_pkg::BYTE_W-1:0]      out_byte_q;
  logic [bfism_pkg::STATUS_W-1:0]    status_q;
  logic [bfism_pkg::NEXT_IP_W-1:0]   next_ip_q;

  // program read address, also the next scan position
  always_comb begin
    unique case (cmd_i.prd_sel)
      bfism_pkg::PRD_K:     rd_addr = scan_k_q;
      bfism_pkg::PRD_IP:    rd_addr = AW'(ip_q);
      bfism_pkg::PRD_IP_P1: rd_addr = AW'(ip_q + IPW'(1));
      bfism_pkg::PRD_IP_M1: rd_addr = AW'(ip_q - IPW'(1));
      bfism_pkg::PRD_K_P1:  rd_addr = scan_k_q + AW'(1);
      bfism_pkg::PRD_K_M1:  rd_addr = scan_k_q - AW'(1);
      default:              rd_addr = scan_k_q;
    endcase
  end

  always_comb begin
    len_d   = len_q;
    ip_d    = ip_q;
    cp_d    = cp_q;
    fault_d = fault_q;
    sweep_d = sweep_q;
    depth_d = depth_q;
    if (cmd_i.clr_regs) begin
      len_d   = '0;
      ip_d    = '0;
      cp_d    = '0;
      fault_d = 1'b0;
      sweep_d = '0;
    end else begin
      if (cmd_i.prog_wr) begin
        len_d = len_q + IPW'(1);
      end
      unique case (cmd_i.ip_sel)
        bfism_pkg::IP_HOLD: ip_d = ip_q;
        bfism_pkg::IP_INC:  ip_d = ip_q + IPW'(1);
        bfism_pkg::IP_SCAN: ip_d = IPW'(scan_k_q) + IPW'(1);
        default:            ip_d = ip_q;
      endcase
      if (cmd_i.cp_inc) begin
        cp_d = cp_q + CW'(1);
      end else if (cmd_i.cp_dec) begin
        cp_d = cp_q - CW'(1);
      end
      if (cmd_i.fault_set) begin
        fault_d = 1'b1;
      end
      if (cmd_i.sweep_wr) begin
        sweep_d = sweep_q + CW'(1);
      end
    end
    if (cmd_i.depth_clr) begin
      depth_d = '0;
    end else if (cmd_i.depth_inc) begin
      depth_d = depth_q + IPW'(1);
    end else if (cmd_i.depth_dec) begin
      depth_d = depth_q - IPW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ip_q    <= '0;
      cp_q    <= '0;
      fault_q <= 1'b0;
      sweep_q <= '0;
      depth_q <= '0;
      done_q  <= 1'b0;
    end else begin
      len_q   <= len_d;
      ip_q    <= ip_d;
      cp_q    <= cp_d;
      fault_q <= fault_d;
      sweep_q <= sweep_d;
      depth_q <= depth_d;
      done_q  <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_k_q <= rd_addr;
    if (cmd_i.latch_in) begin
      in_byte_q <= in_byte_i;
    end
    if (cmd_i.emit) begin
      out_valid_q <= cmd_i.out_sel;
      out_byte_q  <= cmd_i.out_sel ? tape_rd_q : '0;
      status_q    <= cmd_i.status;
      next_ip_q   <= bfism_pkg::NEXT_IP_W'(ip_d);
    end
  end

  // program memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.prog_wr) begin
      prog_mem[AW'(len_q)] <= bfism_pkg::encode(prog_char_i);
    end
    prog_rd_q <= prog_mem[rd_addr];
  end

  // tape memory, cleared by the sweep
  always_comb begin
    tape_we    = cmd_i.sweep_wr | cmd_i.tape_wr;
    tape_waddr = cmd_i.sweep_wr ? sweep_q : cp_q;
    if (cmd_i.sweep_wr) begin
      tape_wdata = '0;
    end else begin
      unique case (cmd_i.tsrc)
        bfism_pkg::TS_INC: tape_wdata = tape_rd_q + 8'd1;
        bfism_pkg::TS_DEC: tape_wdata = tape_rd_q - 8'd1;
        bfism_pkg::TS_IN:  tape_wdata = in_byte_q;
        default:           tape_wdata = tape_rd_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    tape_rd_q <= tape_mem[cp_q];
  end

  assign ip_p1 = {1'b0, ip_q} + (IPW + 1)'(1);
  assign k_p1  = (IPW + 1)'(scan_k_q) + (IPW + 1)'(1);

  always_comb begin
    stat_o            = '0;
    stat_o.op         = bfism_pkg::op_e'(prog_rd_q);
    stat_o.cell_zero  = (tape_rd_q == '0);
    stat_o.fault      = fault_q;
    stat_o.ip_ge_len  = (ip_q >= len_q);
    stat_o.ip1_ge_len = (ip_p1 >= {1'b0, len_q});
    stat_o.ip_zero    = (ip_q == '0);
    stat_o.len_full   = (len_q == IPW'(PROG_DEPTH));
    stat_o.cp_zero    = (cp_q == '0);
    stat_o.cp_last    = (cp_q == CW'(TAPE_DEPTH - 1));
    stat_o.k_last     = (k_p1 >= {1'b0, len_q});
    stat_o.k_zero     = (scan_k_q == '0);
    stat_o.depth_zero = (depth_q == '0);
    stat_o.sweep_last = (sweep_q == CW'(TAPE_DEPTH - 1));
  end

  assign done_o      = done_q;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;
  assign next_ip_o   = next_ip_q;

endmodule

[rtl/core/bf_instruction_step_machine.sv]
// top level of the instruction step machine
//
// Command port: an item (func_i, prog_char_i, in_byte_i) is taken at a rising
// edge with start high and busy low. func_i selects load program character,
// execute one step, or restart. Every item gives exactly one result on
// out_valid_o, out_byte_o, status_o and next_ip_o, marked by done_o for one
// cycle; the receiver must take it then, there is no back pressure.
// Path of an item to its registered result:
//   load, restart, unused func and a step past the program end: from S_IDLE
//   step of a plain instruction or a bracket that does not scan: via S_EXEC
//   bracket scan: via S_EXEC, then S_SCAN_F or S_SCAN_B through the program
// Except after a restart, busy is low again in the cycle done_o is high, so a new item may follow.
// The step rate is set by the registered reads of the program and tape
// memories; the scan reads one program entry per cycle.
// Reset and restart both start a clearing pass that writes zero to every
// tape cell; busy stays high during the pass.
// A restart gives its result at the start of that pass.
module bf_instruction_step_machine #(
  parameter int unsigned PROG_DEPTH = bfism_pkg::PROG_DEPTH_DEF,
  parameter int unsigned TAPE_DEPTH = bfism_pkg::TAPE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [bfism_pkg::FUNC_W-1:0]        func_i,
  input  logic [bfism_pkg::BYTE_W-1:0]        prog_char_i,
  input  logic [bfism_pkg::BYTE_W-1:0]        in_byte_i,
  output logic                                done_o,
  output logic                                out_valid_o,
  output logic [bfism_pkg::BYTE_W-1:0]        out_byte_o,
  output logic [bfism_pkg::STATUS_W-1:0]      status_o,
  output logic [bfism_pkg::NEXT_IP_W-1:0]     next_ip_o
);

  bfism_pkg::dp_cmd_t  cmd;
  bfism_pkg::dp_stat_t stat;

  bfism_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  bfism_datapath #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prog_char_i (prog_char_i),
    .in_byte_i   (in_byte_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .next_ip_o   (next_ip_o)
  );

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == bfism_pkg::FUNC_LOAD) |=> done_o)
    else $error("load item gave no result in the next cycle");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == bfism_pkg::FUNC_RESTART)
      |=> (done_o && busy && next_ip_o == '0 && status_o == bfism_pkg::STAT_OK))
    else $error("restart did not report a cleared pointer and start the clear");

  a_output_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_valid_o) |-> (status_o == bfism_pkg::STAT_OK))
    else $error("output byte reported with an error status");

endmodule
